FILE: hdl/natl_pkg.sv
`timescale 1ns / 1ps
// natl_pkg: request codes, register indexes and field widths for the
// nearest axis table lookup core. No dependencies.

package natl_pkg;

	localparam int REQ_W   = 2;
	localparam int VAL_W   = 8;
	localparam int IDX_W   = 4;
	localparam int ENTRY_W = 7;
	localparam int CNT_W   = 5;
	localparam int CFGI_W  = 1;

	typedef logic [REQ_W-1:0]   req_t;
	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam req_t REQ_QUERY      = 2'd0;
	localparam req_t REQ_WIND_POINT = 2'd1;
	localparam req_t REQ_LOAD_POINT = 2'd2;
	localparam req_t REQ_TABLE_CELL = 2'd3;

	localparam logic [CFGI_W-1:0] CFG_WIND_POINTS = 1'b0;
	localparam logic [CFGI_W-1:0] CFG_LOAD_POINTS = 1'b1;

endpackage

FILE: hdl/nearest_axis_table_lookup_core.sv
`timescale 1ns / 1ps
// nearest_axis_table_lookup_core: wind and load axis memories, angle table
// memory and a shared nearest-point comparator under a small sequencer.
// Depends on natl_pkg.
//
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------
// request  | in        | start, busy               | req_type, wind_value, load_value,
//          |           |                           | row_index, col_index, entry_value
// result   | out       | done (one-cycle strobe)   | angle, wind_index, load_index
// config   | in        | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// write requests complete at the accepting edge; busy stays low
// a query scans nw wind points, then nl load points, then finishes the last compare
// and the table read before done; the next transaction is taken in the cycle after done
// at the earliest; nw and nl are the clamped point counts: the single comparator scans
// one axis point per cycle
// after reset a clearing pass over the MAX_LOAD_POINTS * MAX_WIND_POINTS table cells
// holds busy high; config writes are always taken
// the result receiver cannot stall

module nearest_axis_table_lookup_core
	import natl_pkg::*;
#(
	parameter int MAX_WIND_POINTS = 16,
	parameter int MAX_LOAD_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               req_type,
	input  val_t               wind_value,
	input  val_t               load_value,
	input  logic [IDX_W-1:0]   row_index,
	input  logic [IDX_W-1:0]   col_index,
	input  entry_t             entry_value,
	output logic               done,
	output entry_t             angle,
	output logic [IDX_W-1:0]   wind_index,
	output logic [IDX_W-1:0]   load_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  cnt_t               cfg_data
);

	localparam int WI_W   = (MAX_WIND_POINTS > 1) ? $clog2(MAX_WIND_POINTS) : 1;
	localparam int LI_W   = (MAX_LOAD_POINTS > 1) ? $clog2(MAX_LOAD_POINTS) : 1;
	localparam int SC_W   = (WI_W > LI_W) ? WI_W : LI_W;
	localparam int TAB_D  = MAX_WIND_POINTS * MAX_LOAD_POINTS;
	localparam int TA_W   = (TAB_D > 1) ? $clog2(TAB_D) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_WSCAN = 3'd2;
	localparam logic [2:0] ST_LSCAN = 3'd3;
	localparam logic [2:0] ST_TADDR = 3'd4;
	localparam logic [2:0] ST_TREAD = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]      state_q;
	logic [TA_W-1:0] clr_q;
	logic [SC_W-1:0] sc_q;
	cnt_t            wind_pts_q;
	cnt_t            load_pts_q;

	logic            v_s1;
	logic            last_s1;
	logic            axis_s1;
	logic [SC_W-1:0] idx_s1;
	entry_t          w_rd_s1;
	entry_t          l_rd_s1;

	val_t            wind_q;
	val_t            load_q;
	val_t            bestd_q;
	logic [SC_W-1:0] best_q;
	logic [WI_W-1:0] wind_best_q;
	logic [LI_W-1:0] load_best_q;
	entry_t          tab_rd_q;

	entry_t wind_mem [MAX_WIND_POINTS];
	entry_t load_mem [MAX_LOAD_POINTS];
	entry_t tab_mem  [TAB_D];

	logic            accept;
	logic [7:0]      wpts_ext;
	logic [7:0]      lpts_ext;
	logic [SC_W-1:0] wlast;
	logic [SC_W-1:0] llast;
	logic            scan_last;
	logic            clr_last;

	logic            w_we;
	logic [WI_W-1:0] w_wa;
	entry_t          w_wd;
	logic            l_we;
	logic [LI_W-1:0] l_wa;
	entry_t          l_wd;
	logic            t_we;
	logic [TA_W-1:0] t_wa;
	entry_t          t_wd;
	logic [TA_W-1:0] t_ra;

	val_t            cur_v;
	val_t            cur_p;
	val_t            diff;
	logic            take;
	logic [SC_W-1:0] new_best;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = (state_q == ST_OUT);
	assign angle     = tab_rd_q;
	assign wind_index = IDX_W'(wind_best_q);
	assign load_index = IDX_W'(load_best_q);

	// clamped last index per axis
	always_comb begin
		wpts_ext = 8'(wind_pts_q);
		lpts_ext = 8'(load_pts_q);
		priority if (wpts_ext == 8'd0)
			wlast = '0;
		else if (wpts_ext > 8'(MAX_WIND_POINTS))
			wlast = SC_W'(MAX_WIND_POINTS - 1);
		else
			wlast = SC_W'(wpts_ext - 8'd1);
		priority if (lpts_ext == 8'd0)
			llast = '0;
		else if (lpts_ext > 8'(MAX_LOAD_POINTS))
			llast = SC_W'(MAX_LOAD_POINTS - 1);
		else
			llast = SC_W'(lpts_ext - 8'd1);
	end

	assign scan_last = (state_q == ST_WSCAN) ? (sc_q == wlast) : (sc_q == llast);
	assign clr_last  = (clr_q == TA_W'(TAB_D - 1));

	// shared distance and compare unit
	always_comb begin
		cur_v    = axis_s1 ? load_q : wind_q;
		cur_p    = axis_s1 ? val_t'(l_rd_s1) : val_t'(w_rd_s1);
		diff     = (cur_v >= cur_p) ? (cur_v - cur_p) : (cur_p - cur_v);
		take     = (idx_s1 == '0) || (diff < bestd_q);
		new_best = take ? idx_s1 : best_q;
	end

	// memory write port selection
	always_comb begin
		w_we = 1'b0;
		w_wa = WI_W'(col_index);
		w_wd = entry_value;
		l_we = 1'b0;
		l_wa = LI_W'(row_index);
		l_wd = entry_value;
		t_we = 1'b0;
		t_wa = TA_W'(TA_W'(row_index) * TA_W'(MAX_WIND_POINTS) + TA_W'(col_index));
		t_wd = entry_value;
		if (state_q == ST_CLEAR) begin
			w_we = (32'(clr_q) < MAX_WIND_POINTS);
			w_wa = WI_W'(clr_q);
			w_wd = (clr_q == '0) ? ENTRY_W'(1) : '0;
			l_we = (32'(clr_q) < MAX_LOAD_POINTS);
			l_wa = LI_W'(clr_q);
			l_wd = (clr_q == '0) ? ENTRY_W'(1) : '0;
			t_we = 1'b1;
			t_wa = clr_q;
			t_wd = '0;
		end else if (accept) begin
			w_we = (req_type == REQ_WIND_POINT) && (8'(col_index) < 8'(MAX_WIND_POINTS));
			l_we = (req_type == REQ_LOAD_POINT) && (8'(row_index) < 8'(MAX_LOAD_POINTS));
			t_we = (req_type == REQ_TABLE_CELL) && (8'(col_index) < 8'(MAX_WIND_POINTS))
				&& (8'(row_index) < 8'(MAX_LOAD_POINTS));
		end
		t_ra = TA_W'(TA_W'(load_best_q) * TA_W'(MAX_WIND_POINTS) + TA_W'(wind_best_q));
	end

	always_ff @(posedge clk) begin
		if (w_we)
			wind_mem[w_wa] <= w_wd;
		w_rd_s1 <= wind_mem[sc_q[WI_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (l_we)
			load_mem[l_wa] <= l_wd;
		l_rd_s1 <= load_mem[sc_q[LI_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (t_we)
			tab_mem[t_wa] <= t_wd;
		if (state_q == ST_TREAD)
			tab_rd_q <= tab_mem[t_ra];
	end

	// query payload and compare stage results
	always_ff @(posedge clk) begin
		if (accept) begin
			wind_q <= wind_value;
			load_q <= load_value;
		end
		idx_s1 <= sc_q;
		if (v_s1) begin
			bestd_q <= take ? diff : bestd_q;
			best_q  <= new_best;
			if (last_s1 && !axis_s1)
				wind_best_q <= new_best[WI_W-1:0];
			if (last_s1 && axis_s1)
				load_best_q <= new_best[LI_W-1:0];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_pts_q <= CNT_W'(1);
			load_pts_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WIND_POINTS)
				wind_pts_q <= cfg_data;
			if (cfg_index == CFG_LOAD_POINTS)
				load_pts_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			sc_q    <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			axis_s1 <= 1'b0;
		end else begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + TA_W'(1);
					if (clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					sc_q <= '0;
					if (accept && (req_type == REQ_QUERY))
						state_q <= ST_WSCAN;
				end
				ST_WSCAN, ST_LSCAN: begin
					v_s1    <= 1'b1;
					last_s1 <= scan_last;
					axis_s1 <= (state_q == ST_LSCAN);
					if (scan_last) begin
						sc_q    <= '0;
						state_q <= (state_q == ST_WSCAN) ? ST_LSCAN : ST_TADDR;
					end else begin
						sc_q <= sc_q + SC_W'(1);
					end
				end
				ST_TADDR: state_q <= ST_TREAD;
				ST_TREAD: state_q <= ST_OUT;
				ST_OUT:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_QUERY)) |=> busy)
		else $error("query accepted without going busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type != REQ_QUERY)) |=> !busy)
		else $error("write transaction left the block busy");

	a_wind_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (SC_W'(wind_best_q) <= wlast))
		else $error("wind index beyond points in use");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (SC_W'(load_best_q) <= llast))
		else $error("load index beyond points in use");

	a_compare_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> busy)
		else $error("compare stage active while idle");

endmodule
